FILE: rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int DATA_W  = 32;
	localparam int CNT_W   = 5;
	localparam int TYPE_W  = 3;

	localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_QUERY      = 3'd4;

	localparam logic signed [DATA_W-1:0] NONE_VALUE = '1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	typedef struct packed {
		logic [TYPE_W-1:0]        req_type;
		logic signed [DATA_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic                     underflow;
		logic                     overflow;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		logic                     is_empty;
		logic [CNT_W-1:0]         entry_count;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic capture;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic rsp_free;
	} stat_t;

	function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : i - IDX_W'(1);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/deq_ram.sv
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output      logic [WIDTH-1:0]         rd_data_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output      logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

`default_nettype wire

FILE: rtl/deq_ctrl.sv
`default_nettype none

module deq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output      logic          req_stall,
	output      deq_pkg::cmd_t cmd,
	input  wire deq_pkg::stat_t stat
);

	import deq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				cmd.capture = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (stat.rsp_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/deq_dp.sv
`default_nettype none

module deq_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire deq_pkg::req_t  req,
	input  wire deq_pkg::cmd_t  cmd,
	output      deq_pkg::stat_t stat,
	output      deq_pkg::rsp_t  rsp,
	output      logic           rsp_valid,
	input  wire logic           rsp_stall
);

	import deq_pkg::*;

	logic [TYPE_W-1:0]        type_q;
	logic signed [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]         front_q;
	logic [IDX_W-1:0]         back_q;
	logic [CNT_W-1:0]         count_q;
	logic                     under_q;
	logic                     over_q;
	logic                     pop_ok_q;
	logic signed [DATA_W-1:0] popped_q;
	rsp_t                     rsp_q;
	logic                     rsp_valid_q;

	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic [IDX_W-1:0]         rd_addr_a;
	logic [IDX_W-1:0]         rd_addr_b;
	logic [DATA_W-1:0]        rd_data_a;
	logic [DATA_W-1:0]        rd_data_b;
	logic                     is_full;
	logic                     is_empty;

	assign is_full  = (count_q >= FULL_CNT);
	assign is_empty = (count_q == '0);

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = back_q;
		rd_addr_a = front_q;
		rd_addr_b = idx_down(back_q);
		if (cmd.exec) begin
			case (type_q)
				REQ_PUSH_FRONT: begin
					wr_en   = !is_full;
					wr_addr = idx_down(front_q);
				end
				REQ_PUSH_BACK: begin
					wr_en   = !is_full;
					wr_addr = back_q;
				end
				REQ_POP_FRONT: begin
					rd_addr_a = front_q;
				end
				REQ_POP_BACK: begin
					rd_addr_a = idx_down(back_q);
				end
				default: begin
				end
			endcase
		end
	end

	deq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (value_q),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			type_q  <= req.req_type;
			value_q <= req.push_value;
		end
		if (cmd.exec) begin
			under_q  <= 1'b0;
			over_q   <= 1'b0;
			pop_ok_q <= 1'b0;
			case (type_q)
				REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
					over_q <= is_full;
				end
				REQ_POP_FRONT, REQ_POP_BACK: begin
					under_q  <= is_empty;
					pop_ok_q <= !is_empty;
				end
				default: begin
				end
			endcase
		end
		if (cmd.capture) begin
			popped_q <= pop_ok_q ? signed'(rd_data_a) : NONE_VALUE;
		end
		if (cmd.load_out) begin
			rsp_q.popped_value <= popped_q;
			rsp_q.underflow    <= under_q;
			rsp_q.overflow     <= over_q;
			rsp_q.front_value  <= is_empty ? NONE_VALUE : signed'(rd_data_a);
			rsp_q.back_value   <= is_empty ? NONE_VALUE : signed'(rd_data_b);
			rsp_q.is_empty     <= is_empty;
			rsp_q.entry_count  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			back_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				case (type_q)
					REQ_PUSH_FRONT: begin
						if (!is_full) begin
							front_q <= idx_down(front_q);
							count_q <= count_q + CNT_W'(1);
						end
					end
					REQ_PUSH_BACK: begin
						if (!is_full) begin
							back_q  <= idx_up(back_q);
							count_q <= count_q + CNT_W'(1);
						end
					end
					REQ_POP_FRONT: begin
						if (!is_empty) begin
							front_q <= idx_up(front_q);
							count_q <= count_q - CNT_W'(1);
						end
					end
					REQ_POP_BACK: begin
						if (!is_empty) begin
							back_q  <= idx_down(back_q);
							count_q <= count_q - CNT_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.rsp_free = !rsp_valid_q || !rsp_stall;
	assign rsp           = rsp_q;
	assign rsp_valid     = rsp_valid_q;

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue_top.sv
`default_nettype none

// Double-ended queue of signed 32-bit values in a 16-entry ring memory. Each request
// (push front, push back, pop front, pop back, query; codes five to seven act as query)
// returns one response with the popped value, underflow and overflow flags, and the front
// value, back value, empty flag and count after the request. A pop on an empty queue and
// the front and back values of an empty queue read as -1; a push to a full queue is
// dropped and flagged. From acceptance to the response register a request goes through
// accept, update pointers and write or read the ring, then two registered reads of the
// ring memory (popped entry, then new front and back). The next request is taken once
// the response is loaded, while that response still waits on rsp_stall; a response that
// is not taken holds the block until rsp_stall drops before it can load the next.
module double_ended_queue_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire deq_pkg::req_t req,
	input  wire logic          req_valid,
	output      logic          req_stall,
	output      deq_pkg::rsp_t rsp,
	output      logic          rsp_valid,
	input  wire logic          rsp_stall
);

	import deq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	deq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.entry_count <= FULL_CNT))
		else $error("entry count above depth");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_flags_apart: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.underflow && rsp.overflow))
		else $error("underflow and overflow together");

	a_under_none: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.underflow) |-> (rsp.popped_value == NONE_VALUE && rsp.is_empty))
		else $error("underflow with a popped value");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while busy");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam logic [TYPE_W-1:0] REQ_UNUSED_LO  = 3'd5;
	localparam logic [TYPE_W-1:0] REQ_UNUSED_HI  = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;

	localparam int RANDOM_REQS = 1524;
	localparam int CALM_REQS   = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 20;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		req_t r;
		logic typed;
		rsp_t want;
	} plan_row_t;

	localparam rsp_t EMPTY_QUERY = '{NONE_VALUE, 1'b0, 1'b0, NONE_VALUE, NONE_VALUE, 1'b1, 5'd0};
	localparam rsp_t EMPTY_POP   = '{NONE_VALUE, 1'b1, 1'b0, NONE_VALUE, NONE_VALUE, 1'b1, 5'd0};
	localparam int PLAN_LEN = 26;

	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{'{REQ_QUERY,      32'sd0},           1'b1, EMPTY_QUERY},
		'{'{REQ_POP_FRONT,  32'sd0},           1'b1, EMPTY_POP},
		'{'{REQ_POP_BACK,   32'sh12345678},    1'b1, EMPTY_POP},
		'{'{REQ_PUSH_BACK,  VAL_MAX},          1'b1,
			'{NONE_VALUE, 1'b0, 1'b0, VAL_MAX, VAL_MAX, 1'b0, 5'd1}},
		'{'{REQ_PUSH_FRONT, VAL_MIN},          1'b1,
			'{NONE_VALUE, 1'b0, 1'b0, VAL_MIN, VAL_MAX, 1'b0, 5'd2}},
		'{'{REQ_UNUSED_LO,  32'shFFFFFFFF},    1'b1,
			'{NONE_VALUE, 1'b0, 1'b0, VAL_MIN, VAL_MAX, 1'b0, 5'd2}},
		'{'{REQ_POP_BACK,   32'sd0},           1'b1,
			'{VAL_MAX, 1'b0, 1'b0, VAL_MIN, VAL_MIN, 1'b0, 5'd1}},
		'{'{REQ_POP_FRONT,  32'sd0},           1'b1,
			'{VAL_MIN, 1'b0, 1'b0, NONE_VALUE, NONE_VALUE, 1'b1, 5'd0}},
		'{'{REQ_PUSH_FRONT, 32'sd0},           1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'shFFFFFFFF},    1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'sd1},           1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh55555555},    1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'shAAAAAAAA},    1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh00FF00FF},    1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'shFF00FF00},    1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh0F0F0F0F},    1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'shF0F0F0F0},    1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh33333333},    1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'shCCCCCCCC},    1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh7FFFFFFE},    1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'sh80000001},    1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh12345678},    1'b0, '0},
		'{'{REQ_PUSH_FRONT, 32'shEDCBA987},    1'b0, '0},
		'{'{REQ_PUSH_BACK,  32'sh40000000},    1'b0, '0},
		'{'{REQ_PUSH_FRONT, VAL_MAX},          1'b0, '0},
		'{'{REQ_PUSH_BACK,  VAL_MIN},          1'b0, '0}
	};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	req_t req       = '0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	rsp_t rsp;
	logic rsp_valid;

	logic signed [DATA_W-1:0] slot_mem [DEPTH];
	int   head_idx = 0;
	int   tail_idx = 0;
	int   fill     = 0;

	rsp_t due_q [$];
	rsp_t due;
	int   errors    = 0;
	int   cycle_cnt = 0;
	bit   calm      = 1'b0;
	bit   hold_off  = 1'b0;
	int   stall_rate = 2;

	double_ended_queue_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic rsp_t deq_apply(input req_t r);
		rsp_t o;
		o = '0;
		o.popped_value = NONE_VALUE;
		o.front_value  = NONE_VALUE;
		o.back_value   = NONE_VALUE;
		case (r.req_type)
			REQ_PUSH_FRONT: begin
				if (fill == DEPTH) begin
					o.overflow = 1'b1;
				end else begin
					head_idx = (head_idx + DEPTH - 1) % DEPTH;
					slot_mem[IDX_W'(head_idx)] = r.push_value;
					fill++;
				end
			end
			REQ_PUSH_BACK: begin
				if (fill == DEPTH) begin
					o.overflow = 1'b1;
				end else begin
					slot_mem[IDX_W'(tail_idx)] = r.push_value;
					tail_idx = (tail_idx + 1) % DEPTH;
					fill++;
				end
			end
			REQ_POP_FRONT: begin
				if (fill == 0) begin
					o.underflow = 1'b1;
				end else begin
					o.popped_value = slot_mem[IDX_W'(head_idx)];
					head_idx = (head_idx + 1) % DEPTH;
					fill--;
				end
			end
			REQ_POP_BACK: begin
				if (fill == 0) begin
					o.underflow = 1'b1;
				end else begin
					tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
					o.popped_value = slot_mem[IDX_W'(tail_idx)];
					fill--;
				end
			end
			default: ;
		endcase
		if (fill != 0) begin
			o.front_value = slot_mem[IDX_W'(head_idx)];
			o.back_value  = slot_mem[IDX_W'((tail_idx + DEPTH - 1) % DEPTH)];
		end
		o.is_empty    = (fill == 0);
		o.entry_count = CNT_W'(fill);
		return o;
	endfunction

	// hold the request until accepted, then record what it must return
	task automatic offer(input req_t r, input logic typed, input rsp_t want);
		rsp_t calc;
		req       <= r;
		req_valid <= 1'b1;
		@(negedge clk);
		while (req_stall) @(negedge clk);
		@(posedge clk);
		calc = deq_apply(r);
		due_q.push_back(typed ? want : calc);
	endtask

	task automatic cmp(input string tag, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t %s expected %h actual %h", $realtime, tag, want, got);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_q.size() == 0) begin
				$display("%0t response expected none actual %h", $realtime, rsp);
				errors++;
			end else begin
				due = due_q.pop_front();
				cmp("popped_value", due.popped_value, rsp.popped_value);
				cmp("underflow", DATA_W'(due.underflow), DATA_W'(rsp.underflow));
				cmp("overflow", DATA_W'(due.overflow), DATA_W'(rsp.overflow));
				cmp("front_value", due.front_value, rsp.front_value);
				cmp("back_value", due.back_value, rsp.back_value);
				cmp("is_empty", DATA_W'(due.is_empty), DATA_W'(rsp.is_empty));
				cmp("entry_count", DATA_W'(due.entry_count), DATA_W'(rsp.entry_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 127) == 0) stall_rate = $urandom_range(0, 6);
			if (hold_off) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_off = 1'b0;
			end else if (!calm && $urandom_range(0, 15) < stall_rate) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		int  gap_rate;
		int  pick;
		bit  draining;
		req_t r;
		gap_rate = 0;
		draining = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < PLAN_LEN; k++) begin
			offer(PLAN[k].r, PLAN[k].typed, PLAN[k].want);
		end

		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 64 == 0) gap_rate = $urandom_range(0, 3);
			calm = (n >= RANDOM_REQS - CALM_REQS);
			if (n == 500) hold_off = 1'b1;
			if (fill == DEPTH && $urandom_range(0, 2) == 0) draining = 1'b1;
			else if (fill == 0 && $urandom_range(0, 2) == 0) draining = 1'b0;

			pick = $urandom_range(0, 19);
			if (pick < 2)
				r.req_type = TYPE_W'($urandom_range(REQ_PUSH_FRONT, REQ_UNUSED_HI));
			else if ((pick < 15) == draining)
				r.req_type = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
			else if (pick < 19)
				r.req_type = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
			else
				r.req_type = REQ_QUERY;

			case ($urandom_range(0, 15))
				0:       r.push_value = VAL_MAX;
				1:       r.push_value = VAL_MIN;
				2:       r.push_value = NONE_VALUE;
				3:       r.push_value = '0;
				default: r.push_value = $urandom();
			endcase

			if (!calm && $urandom_range(0, 7) < gap_rate) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			offer(r, 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
